[rtl/gradient_energy_map_top_macros.svh]
// Assertion macros for the gradient energy map block.
// Used by the top level; relies on clk and rst being in scope.
`ifndef GRADIENT_ENERGY_MAP_TOP_MACROS_SVH
`define GRADIENT_ENERGY_MAP_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define GEM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked also across reset
`define GEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/gem_pkg.sv]
// Shared constants, queue word type and energy function for the gradient energy map.
// No dependencies; imported by every module of the block.
package gem_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 16;
  localparam int PIX_W     = 8;
  localparam int E_W       = 10;
  localparam int CFG_W     = 16;
  localparam int WREG_W    = 13;
  localparam int CFG_IDX_W = 2;

  // Queue between front and back (depth must be a power of two)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Register reset values, stored as last column / last row
  localparam logic [COL_W-1:0] WIDTH_LAST_RST  = COL_W'(639);
  localparam logic [ROW_W-1:0] HEIGHT_LAST_RST = ROW_W'(479);

  // Result kinds one pixel can release, in output order
  localparam int NUM_RES = 3;
  localparam int RES_W   = $clog2(NUM_RES);
  localparam logic [RES_W-1:0] RES_UP     = RES_W'(0);  // pixel one row above
  localparam logic [RES_W-1:0] RES_LEFT   = RES_W'(1);  // left neighbor on last row
  localparam logic [RES_W-1:0] RES_CORNER = RES_W'(2);  // bottom right pixel itself

  // One queue word: all energies released by one pixel
  typedef struct packed {
    logic [NUM_RES-1:0]          kinds;
    logic [ROW_W-1:0]            row;
    logic [COL_W-1:0]            col;
    logic [NUM_RES-1:0][E_W-1:0] energy;
  } gem_item_t;

  // Doubled L1 energy: one-sided differences count twice, central ones once
  function automatic logic [E_W-1:0] energy2(
    input logic [PIX_W-1:0] hl,
    input logic [PIX_W-1:0] hr,
    input logic             h_edge,
    input logic [PIX_W-1:0] vt,
    input logic [PIX_W-1:0] vb,
    input logic             v_edge
  );
    logic [PIX_W-1:0] dh;
    logic [PIX_W-1:0] dv;
    logic [PIX_W:0]   sh;
    logic [PIX_W:0]   sv;
    dh = (hl > hr) ? (hl - hr) : (hr - hl);
    dv = (vt > vb) ? (vt - vb) : (vb - vt);
    sh = h_edge ? {dh, 1'b0} : {1'b0, dh};
    sv = v_edge ? {dv, 1'b0} : {1'b0, dv};
    return E_W'(sh) + E_W'(sv);
  endfunction

endpackage

[rtl/gem_front.sv]
// Front end: config registers, raster counters, line buffers and energy operands.
// Depends on gem_pkg; pushes one word per pixel that releases results.
module gem_front import gem_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 pixel_valid,
  output logic                 pixel_ready,
  input  logic [PIX_W-1:0]     pixel,
  input  logic [QCNT_W-1:0]    q_count,
  output logic                 push,
  output gem_item_t            push_item
);

  logic [COL_W-1:0] width_last;
  logic [COL_W-1:0] width_last_next;
  logic [ROW_W-1:0] height_last;
  logic [ROW_W-1:0] height_last_next;
  logic [WREG_W-1:0] cfg_w;
  logic             cfg_we;
  logic             cfg_hit;

  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_plus1;
  logic             col_at_end;
  logic             row_at_end;
  logic             pixel_accept;
  logic [PIX_W-1:0] left1;
  logic [PIX_W-1:0] left2;

  // Line buffers
  logic [PIX_W-1:0] recent_line [MAX_WIDTH];
  logic [PIX_W-1:0] older_line  [MAX_WIDTH];
  logic [PIX_W-1:0] rec_a;
  logic [PIX_W-1:0] rec_b;
  logic [PIX_W-1:0] old_a;

  // Operand stage
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic             s1_has_up;
  logic             s1_a0;
  logic             s1_c0;
  logic             s1_b0;
  logic             s1_cl;
  logic             s1_last_row;
  logic [PIX_W-1:0] s1_left1;
  logic [PIX_W-1:0] s1_left2;
  logic             fwd_b;
  logic [PIX_W-1:0] fwd_pix;
  logic [PIX_W-1:0] prev_rec;

  logic [PIX_W-1:0] rec_n;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] hl_up;
  logic [PIX_W-1:0] hr_up;
  logic [PIX_W-1:0] hl_left;

  // Config port is always ready; only known indexes restart the frame
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_we && ((cfg_index == CFG_FRAME_WIDTH) ||
                                (cfg_index == CFG_FRAME_HEIGHT));
  assign cfg_w     = cfg_data[WREG_W-1:0];

  // Clamp width to 2..MAX_WIDTH and height to at least 2
  always_comb begin
    if (cfg_w < WREG_W'(2)) begin
      width_last_next = COL_W'(1);
    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
      width_last_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last_next = COL_W'(cfg_w - WREG_W'(1));
    end
    if (cfg_data < CFG_W'(2)) begin
      height_last_next = ROW_W'(1);
    end else begin
      height_last_next = ROW_W'(cfg_data - CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= WIDTH_LAST_RST;
      height_last <= HEIGHT_LAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width_last  <= width_last_next;
        CFG_FRAME_HEIGHT: height_last <= height_last_next;
        default: ;
      endcase
    end
  end

  // Credit check: room for the word in flight and the one taken now
  assign pixel_ready  = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid)) <
                        (QCNT_W + 1)'(QDEPTH);
  assign pixel_accept = pixel_valid && pixel_ready;

  assign col_at_end = (col == width_last);
  assign row_at_end = (row == height_last);
  assign col_plus1  = col + COL_W'(1);

  // Raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (cfg_hit) begin
      row <= '0;
      col <= '0;
    end else if (pixel_accept) begin
      if (col_at_end) begin
        col <= '0;
        row <= row_at_end ? '0 : (row + ROW_W'(1));
      end else begin
        col <= col_plus1;
      end
    end
  end

  // Two previous pixels of the stream
  always_ff @(posedge clk) begin
    if (rst) begin
      left1 <= '0;
      left2 <= '0;
    end else if (pixel_accept) begin
      left1 <= pixel;
      left2 <= left1;
    end
  end

  // Line buffer reads at accept, writes in the following cycle
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      rec_a <= recent_line[col];
      rec_b <= recent_line[col_plus1];
      old_a <= older_line[col];
    end
    if (s1_valid) begin
      recent_line[s1_col] <= s1_pixel;
      older_line[s1_col]  <= rec_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pixel_accept;
    end
  end

  // Operand stage payload
  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_pixel    <= pixel;
      s1_row      <= row;
      s1_col      <= col;
      s1_has_up   <= (row != '0);
      s1_a0       <= (row == ROW_W'(1));
      s1_c0       <= (col == '0);
      s1_b0       <= (col == COL_W'(1));
      s1_cl       <= col_at_end;
      s1_last_row <= row_at_end;
      s1_left1    <= left1;
      s1_left2    <= left2;
      // next column is being written this edge on two-pixel rows
      fwd_b       <= s1_valid && (s1_col == col_plus1);
      fwd_pix     <= s1_pixel;
    end
    // above-row pixel of the previous column
    if (s1_valid) begin
      prev_rec <= rec_a;
    end
  end

  // Neighbor selection at frame borders
  assign rec_n   = fwd_b ? fwd_pix : rec_b;
  assign top     = s1_a0 ? rec_a : old_a;
  assign hl_up   = s1_c0 ? rec_a : prev_rec;
  assign hr_up   = s1_cl ? rec_a : rec_n;
  assign hl_left = s1_b0 ? s1_left1 : s1_left2;

  always_comb begin
    push_item                    = '0;
    push_item.row                = s1_row;
    push_item.col                = s1_col;
    push_item.kinds[RES_UP]      = s1_has_up;
    push_item.kinds[RES_LEFT]    = s1_last_row && !s1_c0;
    push_item.kinds[RES_CORNER]  = s1_last_row && s1_cl;
    push_item.energy[RES_UP]     = energy2(hl_up, hr_up, s1_c0 || s1_cl,
                                           top, s1_pixel, s1_a0);
    push_item.energy[RES_LEFT]   = energy2(hl_left, s1_pixel, s1_b0,
                                           prev_rec, s1_left1, 1'b1);
    push_item.energy[RES_CORNER] = energy2(s1_left1, s1_pixel, 1'b1,
                                           rec_a, s1_pixel, 1'b1);
  end

  // Row zero releases nothing
  assign push = s1_valid && (push_item.kinds != '0);

endmodule

[rtl/gem_queue.sv]
// Short queue of pixel words between the front end and the result sequencer.
// Depends on gem_pkg for the word type and depth.
module gem_queue import gem_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gem_item_t         push_item,
  input  logic              pop,
  output gem_item_t         head_item,
  output logic [QCNT_W-1:0] q_count
);

  gem_item_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   q_count <= q_count + QCNT_W'(1);
        2'b01:   q_count <= q_count - QCNT_W'(1);
        default: q_count <= q_count;
      endcase
    end
  end

  assign head_item = slots[rd_ptr];

endmodule

[rtl/gem_back.sv]
// Back end: walks head-word results one per unstalled cycle into the output register.
// Depends on gem_pkg for the word type and result kinds.
module gem_back import gem_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  gem_item_t        head_item,
  output logic             pop,
  output logic             energy_valid,
  input  logic             energy_ready,
  output logic [E_W-1:0]   energy_doubled,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic             last_of_run,
  output logic             frame_done
);

  logic [NUM_RES-1:0] done_mask;
  logic [NUM_RES-1:0] pending;
  logic [NUM_RES-1:0] sel_bit;
  logic [RES_W-1:0]   sel;
  logic               is_last;
  logic               load;

  // Lowest kind not yet sent from the head word
  assign pending = head_item.kinds & ~done_mask;

  always_comb begin
    sel = RES_CORNER;
    if (pending[RES_LEFT]) begin
      sel = RES_LEFT;
    end
    if (pending[RES_UP]) begin
      sel = RES_UP;
    end
  end

  assign sel_bit = NUM_RES'(1) << sel;
  assign is_last = ((pending & ~sel_bit) == '0);
  assign load    = q_valid && (!energy_valid || energy_ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_valid <= 1'b0;
      done_mask    <= '0;
    end else begin
      if (load) begin
        energy_valid <= 1'b1;
        done_mask    <= is_last ? '0 : (done_mask | sel_bit);
      end else if (energy_ready) begin
        energy_valid <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (load) begin
      energy_doubled <= head_item.energy[sel];
      last_of_run    <= is_last;
      frame_done     <= (sel == RES_CORNER);
      unique case (sel)
        RES_UP: begin
          out_row <= head_item.row - ROW_W'(1);
          out_col <= head_item.col;
        end
        RES_LEFT: begin
          out_row <= head_item.row;
          out_col <= head_item.col - COL_W'(1);
        end
        default: begin
          out_row <= head_item.row;
          out_col <= head_item.col;
        end
      endcase
    end
  end

endmodule

[rtl/gradient_energy_map_top.sv]
// Gradient energy map: one pixel accepted per cycle while the queue has credit; each
// result passes the operand stage and queue into the output register (one row late
// in the stream). Output side gives one word per cycle while energy_ready allows, so
// last-row pixels past column 0 give two words each, the frame's last pixel three.
// Synchronous reset clears counters, queue and valids, width 640, height 480;
// line buffers are not cleared and no clearing pass runs.
`include "gradient_energy_map_top_macros.svh"

module gradient_energy_map_top import gem_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 pixel_valid,
  output logic                 pixel_ready,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 energy_valid,
  input  logic                 energy_ready,
  output logic [E_W-1:0]       energy_doubled,
  output logic [ROW_W-1:0]     out_row,
  output logic [COL_W-1:0]     out_col,
  output logic                 last_of_run,
  output logic                 frame_done
);

  logic              push;
  gem_item_t         push_item;
  logic              pop;
  gem_item_t         head_item;
  logic [QCNT_W-1:0] q_count;
  logic              q_valid;

  assign q_valid = (q_count != '0);

  // Counters, line buffers, operands
  gem_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .q_count     (q_count),
    .push        (push),
    .push_item   (push_item)
  );

  // Decoupling queue
  gem_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_count   (q_count)
  );

  // Result sequencer and output register
  gem_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .head_item      (head_item),
    .pop            (pop),
    .energy_valid   (energy_valid),
    .energy_ready   (energy_ready),
    .energy_doubled (energy_doubled),
    .out_row        (out_row),
    .out_col        (out_col),
    .last_of_run    (last_of_run),
    .frame_done     (frame_done)
  );

  // Credit scheme must never push into a full queue
  `GEM_ASSERT_IMPLY(a_push_room, push, q_count < QCNT_W'(QDEPTH), "push into full queue")
  // The corner result is always the final word of its pixel
  `GEM_ASSERT_IMPLY(a_done_last, energy_valid && frame_done, last_of_run, "frame_done not last")
  // Reset leaves nothing queued or shown
  `GEM_ASSERT_NEXT(a_reset_idle, rst, !energy_valid && (q_count == '0), "busy after reset")

endmodule

[verif/tb_gradient_energy_map_top.sv]
// Testbench for gradient_energy_map_top: drives raster-order pixels and frame registers,
// predicts every energy word in a small scoreboard class and checks the output stream.
// Depends on rtl/gem_pkg.sv and rtl/gradient_energy_map_top.sv.
`timescale 1ns / 1ps

module tb_gradient_energy_map_top import gem_pkg::*; ();

  localparam int          DRAIN_CYCLES   = 12;       // margin for the output lag
  localparam int          SETTLE_LIMIT   = 5000;
  localparam int          RANDOM_PIXELS  = 160;      // pixel budget through the random frames
  localparam int          HOLD_CYCLES    = 80;       // long receiver hold-off
  localparam longint      RUN_LIMIT_NS   = 10_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(3);  // no register here

  // Pixel content styles for random frames
  localparam int STYLE_NOISE   = 0;
  localparam int STYLE_EXTREME = 1;
  localparam int STYLE_SMOOTH  = 2;

  typedef logic [PIX_W-1:0] pixel_q_t[$];

  // One output word: field order matches the port concatenation in the monitor
  typedef struct packed {
    logic [E_W-1:0]   energy;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             done;
  } energy_word_t;

  // Scoreboard: tracks line buffers and counters, queues the energies each pixel releases
  class energy_predictor;
    logic [PIX_W-1:0] older_row  [MAX_WIDTH];
    logic [PIX_W-1:0] recent_row [MAX_WIDTH];
    logic [15:0]      left_pair;
    int unsigned      row_at, col_at, width_reg, height_reg;
    energy_word_t     energies_due[$];
    int               errors, words_checked, pixels_noted;

    function new();
      left_pair  = '0;
      row_at     = 0;
      col_at     = 0;
      width_reg  = 640;
      height_reg = 480;
    endfunction

    // Twice the L1 gradient: border differences are one-sided, so they count double
    function logic [E_W-1:0] energy_x2(int unsigned hl, int unsigned hr, bit h_edge,
                                       int unsigned vt, int unsigned vb, bit v_edge);
      int unsigned dh, dv;
      dh = (hl > hr) ? hl - hr : hr - hl;
      dv = (vt > vb) ? vt - vb : vb - vt;
      if (h_edge) dh = dh * 2;
      if (v_edge) dv = dv * 2;
      return E_W'(dh + dv);
    endfunction

    function energy_word_t word_of(logic [E_W-1:0] e, int unsigned row, int unsigned col,
                                   bit done);
      energy_word_t wd;
      wd.energy = e;
      wd.row    = ROW_W'(row);
      wd.col    = COL_W'(col);
      wd.last   = 1'b0;
      wd.done   = done;
      return wd;
    endfunction

    // Any write to a real register restarts the frame; buffers keep their data
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_FRAME_WIDTH) width_reg = data & 16'h1FFF;
      else if (idx == CFG_FRAME_HEIGHT) height_reg = data;
      else return;
      row_at = 0;
      col_at = 0;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] p);
      int unsigned  w, h, r, c, a, b, hl, hr, top;
      energy_word_t run[3];
      int           n;
      w = (width_reg < 2) ? 2 : width_reg;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = (height_reg < 2) ? 2 : height_reg;
      r = row_at;
      c = col_at;
      n = 0;
      if (c >= w) c = w - 1;
      // pixel one row up
      if (r >= 1) begin
        a   = r - 1;
        top = (a == 0) ? recent_row[c] : older_row[c];
        hl  = (c > 0) ? older_row[c - 1] : recent_row[c];
        hr  = (c < w - 1) ? recent_row[c + 1] : recent_row[c];
        run[n] = word_of(energy_x2(hl, hr, (c == 0) || (c == w - 1), top, p, a == 0),
                         a, c, 1'b0);
        n++;
      end
      // left neighbor on the last row
      if (r == h - 1 && c >= 1) begin
        b  = c - 1;
        hl = (b > 0) ? left_pair[15:8] : left_pair[7:0];
        run[n] = word_of(energy_x2(hl, p, b == 0, older_row[b], left_pair[7:0], 1'b1),
                         r, b, 1'b0);
        n++;
      end
      // bottom right corner releases itself
      if (r == h - 1 && c == w - 1) begin
        run[n] = word_of(energy_x2(left_pair[7:0], p, 1'b1, recent_row[c], p, 1'b1),
                         r, c, 1'b1);
        n++;
      end
      for (int k = 0; k < n; k++) begin
        run[k].last = (k == n - 1);
        energies_due.push_back(run[k]);
      end
      older_row[c]  = recent_row[c];
      recent_row[c] = p;
      left_pair     = {left_pair[7:0], p};
      if (c + 1 >= w) begin
        col_at = 0;
        row_at = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_at = c + 1;
      end
      pixels_noted++;
    endfunction

    function void check_word(energy_word_t got);
      energy_word_t want;
      words_checked++;
      if (energies_due.size() == 0) begin
        errors++;
        $display("%0t ERROR: unexpected word, expected none, got energy %0d row %0d col %0d",
                 $time, got.energy, got.row, got.col);
        return;
      end
      want = energies_due.pop_front();
      if (got.energy !== want.energy) begin
        errors++;
        $display("%0t ERROR: energy_doubled expected %0d actual %0d (row %0d col %0d)",
                 $time, want.energy, got.energy, want.row, want.col);
      end
      if (got.row !== want.row) begin
        errors++;
        $display("%0t ERROR: out_row expected %0d actual %0d", $time, want.row, got.row);
      end
      if (got.col !== want.col) begin
        errors++;
        $display("%0t ERROR: out_col expected %0d actual %0d", $time, want.col, got.col);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t ERROR: last_of_run expected %0b actual %0b (row %0d col %0d)",
                 $time, want.last, got.last, want.row, want.col);
      end
      if (got.done !== want.done) begin
        errors++;
        $display("%0t ERROR: frame_done expected %0b actual %0b (row %0d col %0d)",
                 $time, want.done, got.done, want.row, want.col);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 pixel_valid;
  logic                 pixel_ready;
  logic [PIX_W-1:0]     pixel;
  logic                 energy_valid;
  logic                 energy_ready;
  logic [E_W-1:0]       energy_doubled;
  logic [ROW_W-1:0]     out_row;
  logic [COL_W-1:0]     out_col;
  logic                 last_of_run;
  logic                 frame_done;

  energy_predictor predictor = new();
  bit              calm       = 1'b0;   // no idling on either side
  bit              hold_armed = 1'b0;   // receiver starts a long hold on next word
  int              settings_used = 0;

  gradient_energy_map_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_valid    (pixel_valid),
    .pixel_ready    (pixel_ready),
    .pixel          (pixel),
    .energy_valid   (energy_valid),
    .energy_ready   (energy_ready),
    .energy_doubled (energy_doubled),
    .out_row        (out_row),
    .out_col        (out_col),
    .last_of_run    (last_of_run),
    .frame_done     (frame_done)
  );

  always #10 clk = ~clk;

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // Output side: check accepted words, random stalls and one long hold-off
  initial begin : energy_sink
    int hold_left;
    hold_left    = 0;
    energy_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        energy_ready <= 1'b0;
      end else begin
        if (energy_valid === 1'b1 && energy_ready) begin
          predictor.check_word({energy_doubled, out_row, out_col, last_of_run, frame_done});
          if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
          end
        end
        if (hold_left > 0) begin
          hold_left--;
          energy_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          hold_left    = $urandom_range(0, 8);
          energy_ready <= 1'b0;
        end else begin
          energy_ready <= 1'b1;
        end
      end
    end
  end

  // Register write; keep valid high when another write follows at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (!more) cfg_valid <= 1'b0;
    predictor.write_reg(idx, data);
  endtask

  task automatic setup_frame(input logic [CFG_W-1:0] w_data, input logic [CFG_W-1:0] h_data);
    write_reg(CFG_FRAME_WIDTH, w_data, 1'b1);
    write_reg(CFG_FRAME_HEIGHT, h_data, 1'b0);
    settings_used++;
  endtask

  // Offer one pixel word, maybe after an idle burst, and hold it until taken
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_ready !== 1'b1);
    predictor.note_pixel(p);
  endtask

  // Wait for every expected word, then let the pipeline empty
  task automatic settle();
    for (int k = 0; k < SETTLE_LIMIT && predictor.energies_due.size() != 0; k++)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic stream(input pixel_q_t data);
    foreach (data[i]) send_pixel(data[i]);
    pixel_valid <= 1'b0;
    settle();
  endtask

  function automatic pixel_q_t random_pixels_of(int count, int style);
    pixel_q_t q;
    int       prev;
    prev = $urandom_range(0, 255);
    for (int i = 0; i < count; i++) begin
      case (style)
        STYLE_EXTREME: prev = $urandom_range(0, 1) ? 255 : 0;
        STYLE_SMOOTH: begin
          prev = prev + $urandom_range(0, 16) - 8;
          if (prev < 0) prev = 0;
          if (prev > 255) prev = 255;
        end
        default: prev = $urandom_range(0, 255);
      endcase
      q.push_back(PIX_W'(prev));
    end
    return q;
  endfunction

  // Main sequence
  initial begin
    int               w, h, count, random_pixels;
    logic [CFG_W-1:0] w_data, h_data;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    pixel_valid <= 1'b0;
    pixel       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frame: interior pixel, every border and the corner, extreme values
    setup_frame(16'd3, 16'd3);
    stream('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128});

    // width and height below range act as 2; two frames back to back wrap
    setup_frame(16'd0, 16'd1);
    stream('{8'd255, 8'd0, 8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127});

    // write to an index with no register behind it
    write_reg(CFG_SPARE_IDX, 16'hFFFF, 1'b0);

    // frame cut short mid-row; the next register write restarts it
    setup_frame(16'd5, 16'd4);
    stream('{8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255});

    // 16x8 frame while the receiver holds off long enough to stall the input
    hold_armed = 1'b1;
    setup_frame(16'd16, 16'd8);
    stream(random_pixels_of(128, STYLE_NOISE));
    random_pixels = 128;

    // random small frames: full, doubled, or cut short
    while (random_pixels < RANDOM_PIXELS) begin
      w = $urandom_range(2, 9);
      h = $urandom_range(2, 6);
      if ($urandom_range(0, 4) == 0) begin
        w_data = CFG_W'($urandom_range(0, 1));
        w      = 2;
      end else begin
        w_data = CFG_W'(w);
      end
      if ($urandom_range(0, 4) == 0) begin
        h_data = CFG_W'($urandom_range(0, 1));
        h      = 2;
      end else begin
        h_data = CFG_W'(h);
      end
      case ($urandom_range(0, 3))
        0:       count = $urandom_range(1, w * h - 1);
        1:       count = 2 * w * h;
        default: count = w * h;
      endcase
      // keep the total pixel count near budget
      if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;
      setup_frame(w_data, h_data);
      stream(random_pixels_of(count, $urandom_range(STYLE_NOISE, STYLE_SMOOTH)));
      random_pixels += count;
    end

    // tallest frame, width bits above the register masked off; abandoned early
    setup_frame(16'h2002, 16'hFFFF);
    stream(random_pixels_of(40, STYLE_NOISE));

    // widest frame, first row only; no idling from here on
    calm = 1'b1;
    setup_frame(16'hFFFF, 16'd2);
    stream(random_pixels_of(16, STYLE_NOISE));

    // closing full frame with words back to back
    setup_frame(16'd6, 16'd4);
    stream(random_pixels_of(24, STYLE_NOISE));

    if (predictor.energies_due.size() != 0) begin
      predictor.errors++;
      $display("%0t ERROR: %0d expected energy words never arrived",
               $time, predictor.energies_due.size());
    end
    $display("Checked %0d energy words from %0d pixels over %0d frame settings.",
             predictor.words_checked, predictor.pixels_noted, settings_used);
    $display("Widths 2 to 16 plus a clamped %0d start, tall frame, restarts, long stall.",
             MAX_WIDTH);
    if (predictor.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
